// ----- design/sadt_pkg.sv -----
// Shared types and codes for the scanned converter deadband tracker.
// No dependencies; used by every module in the design folder.
package sadt_pkg;

    localparam int VALUE_W   = 12;
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 5;
    localparam int BTN_W     = 2;
    localparam int CFG_IDX_W = 4;

    localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LEVEL = 4'd1;

    localparam logic [VALUE_W-1:0] DEADBAND_RESET     = 12'd10;
    localparam logic [VALUE_W-1:0] BUTTON_LEVEL_RESET = 12'd100;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] sample;
        logic [CHAN_W-1:0]  channel;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  sampled_channel;
        logic               sample_changed;
        logic [CHAN_W-1:0]  next_channel;
        logic [VALUE_W-1:0] read_value;
        logic               read_changed;
    } store_res_t;

    typedef struct packed {
        logic [BTN_W-1:0] state;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] released;
    } button_t;

endpackage

// ----- design/sadt_store.sv -----
// Per-channel value store, deadband compare, changed flags and scan position.
// Depends on sadt_pkg.
module sadt_store #(
    parameter int MUX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  sadt_pkg::item_t                item,
    input  logic [sadt_pkg::VALUE_W-1:0]   deadband,
    output sadt_pkg::store_res_t           res,
    output logic [sadt_pkg::VALUE_W-1:0]   btn0_value,
    output logic [sadt_pkg::VALUE_W-1:0]   btn1_value
);

    localparam int TOTAL = MUX_CHANNELS + 2;
    localparam int POS_W = $clog2(TOTAL);
    localparam int VW    = sadt_pkg::VALUE_W;
    localparam logic [VW-1:0] MASK =
        (SAMPLE_BITS >= VW) ? {VW{1'b1}} : VW'((1 << SAMPLE_BITS) - 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOTAL - 1);
    localparam logic [POS_W-1:0] BTN0_POS = POS_W'(MUX_CHANNELS);
    localparam logic [POS_W-1:0] BTN1_POS = POS_W'(MUX_CHANNELS + 1);

    logic [VW-1:0]    values_reg   [TOTAL];
    logic [VW-1:0]    reported_reg [TOTAL];
    logic [TOTAL-1:0] flags_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic             is_sample;
    logic             is_clear;
    logic [VW-1:0]    smp;
    logic [VW-1:0]    rep;
    logic [VW-1:0]    diff;
    logic             changed;
    logic             in_range;
    logic [POS_W-1:0] ch_idx;

    always_comb
    begin
        is_sample = (item.operation == sadt_pkg::OP_SAMPLE);
        is_clear  = (item.operation == sadt_pkg::OP_READ_CLEAR);
        smp       = item.sample & MASK;
        rep       = reported_reg[pos_reg];
        diff      = (smp >= rep) ? (smp - rep) : (rep - smp);
        changed   = is_sample && (diff > deadband);
        in_range  = (item.channel < sadt_pkg::CHAN_W'(TOTAL));
        ch_idx    = item.channel[POS_W-1:0];

        pos_next = pos_reg;
        if (is_sample)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end

        res.sampled_channel = is_sample ? sadt_pkg::CHAN_W'(pos_reg) : '0;
        res.sample_changed  = changed;
        res.next_channel    = sadt_pkg::CHAN_W'(pos_next);
        res.read_value      = (!is_sample && in_range) ? values_reg[ch_idx] : '0;
        res.read_changed    = (!is_sample && in_range) ? flags_reg[ch_idx] : 1'b0;

        btn0_value = (is_sample && pos_reg == BTN0_POS) ? smp : values_reg[BTN0_POS];
        btn1_value = (is_sample && pos_reg == BTN1_POS) ? smp : values_reg[BTN1_POS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++)
            begin
                values_reg[i]   <= '0;
                reported_reg[i] <= '0;
            end
            flags_reg <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            if (is_sample)
            begin
                values_reg[pos_reg] <= smp;
                if (changed)
                begin
                    reported_reg[pos_reg] <= smp;
                    flags_reg[pos_reg]    <= 1'b1;
                end
            end
            else if (is_clear && in_range)
            begin
                flags_reg[ch_idx] <= 1'b0;
            end
        end
    end

endmodule

// ----- design/sadt_buttons.sv -----
// Button level compare and press/release edge tracking on the two direct channels.
// Depends on sadt_pkg.
module sadt_buttons (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         is_sample,
    input  logic [sadt_pkg::VALUE_W-1:0] btn0_value,
    input  logic [sadt_pkg::VALUE_W-1:0] btn1_value,
    input  logic [sadt_pkg::VALUE_W-1:0] level,
    output sadt_pkg::button_t            buttons
);

    sadt_pkg::button_t buttons_reg;
    logic [sadt_pkg::BTN_W-1:0] state;
    logic [sadt_pkg::BTN_W-1:0] edges;

    always_comb
    begin
        state   = {btn1_value < level, btn0_value < level};
        edges   = state ^ buttons_reg.state;
        buttons = buttons_reg;
        if (is_sample)
        begin
            buttons.state    = state;
            buttons.pressed  = edges & state;
            buttons.released = edges & ~state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg <= '0;
        end
        else if (fire)
        begin
            buttons_reg <= buttons;
        end
    end

endmodule

// ----- design/scanned_adc_deadband_tracker.sv -----
// Scanned converter tracker: channel store with deadband, button edges, result register.
// Depends on sadt_pkg, sadt_store and sadt_buttons.
// Result path: input register, then result register; out_stall can hold an item between.
// Throughput: one item per cycle unless the output stalls; one compare and update each.
// Reset: asynchronous, active low; clears all stored values, flags, scan position,
// button history and restores deadband 10 and button level 100.
module scanned_adc_deadband_tracker #(
    parameter int MUX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sadt_pkg::OP_W-1:0]      operation,
    input  logic [sadt_pkg::VALUE_W-1:0]   sample,
    input  logic [sadt_pkg::CHAN_W-1:0]    channel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sadt_pkg::CHAN_W-1:0]    sampled_channel,
    output logic                           sample_changed,
    output logic [sadt_pkg::CHAN_W-1:0]    next_channel,
    output logic [sadt_pkg::VALUE_W-1:0]   read_value,
    output logic                           read_changed,
    output logic [sadt_pkg::BTN_W-1:0]     buttons_state,
    output logic [sadt_pkg::BTN_W-1:0]     buttons_pressed,
    output logic [sadt_pkg::BTN_W-1:0]     buttons_released,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sadt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sadt_pkg::VALUE_W-1:0]   cfg_data
);

    sadt_pkg::item_t      item_reg;
    logic                 item_valid_reg;
    sadt_pkg::store_res_t res_reg;
    sadt_pkg::button_t    btn_out_reg;
    logic                 out_valid_reg;
    logic [sadt_pkg::VALUE_W-1:0] deadband_reg;
    logic [sadt_pkg::VALUE_W-1:0] level_reg;

    sadt_pkg::store_res_t res;
    sadt_pkg::button_t    buttons;
    logic [sadt_pkg::VALUE_W-1:0] btn0_value;
    logic [sadt_pkg::VALUE_W-1:0] btn1_value;
    logic advance;
    logic accept;
    logic fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = item_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign fire      = item_valid_reg && advance;
    assign cfg_ready = 1'b1;

    sadt_store #(
        .MUX_CHANNELS (MUX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .deadband   (deadband_reg),
        .res        (res),
        .btn0_value (btn0_value),
        .btn1_value (btn1_value)
    );

    sadt_buttons u_buttons (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .is_sample  (item_reg.operation == sadt_pkg::OP_SAMPLE),
        .btn0_value (btn0_value),
        .btn1_value (btn1_value),
        .level      (level_reg),
        .buttons    (buttons)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            deadband_reg   <= sadt_pkg::DEADBAND_RESET;
            level_reg      <= sadt_pkg::BUTTON_LEVEL_RESET;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sadt_pkg::REG_DEADBAND)
                begin
                    deadband_reg <= cfg_data;
                end
                else if (cfg_index == sadt_pkg::REG_BUTTON_LEVEL)
                begin
                    level_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation <= operation;
            item_reg.sample    <= sample;
            item_reg.channel   <= channel;
        end
        if (fire)
        begin
            res_reg     <= res;
            btn_out_reg <= buttons;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sampled_channel  = res_reg.sampled_channel;
    assign sample_changed   = res_reg.sample_changed;
    assign next_channel     = res_reg.next_channel;
    assign read_value       = res_reg.read_value;
    assign read_changed     = res_reg.read_changed;
    assign buttons_state    = btn_out_reg.state;
    assign buttons_pressed  = btn_out_reg.pressed;
    assign buttons_released = btn_out_reg.released;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for scanned_adc_deadband_tracker: a scoreboard class mirrors the scan
// store, the deadband, the changed flags and the button edges; plain tasks drive the ports.
// Depends on sadt_pkg and the design folder.

typedef struct {
    logic [sadt_pkg::CHAN_W-1:0]  sampled_channel;
    logic                         sample_changed;
    logic [sadt_pkg::CHAN_W-1:0]  next_channel;
    logic [sadt_pkg::VALUE_W-1:0] read_value;
    logic                         read_changed;
    logic [sadt_pkg::BTN_W-1:0]   buttons_state;
    logic [sadt_pkg::BTN_W-1:0]   buttons_pressed;
    logic [sadt_pkg::BTN_W-1:0]   buttons_released;
} tracker_result_t;

class tracker_scoreboard;
    localparam int SCAN_LEN    = 18;
    localparam int BUTTON_BASE = 16;

    logic [sadt_pkg::VALUE_W-1:0] deadband;
    logic [sadt_pkg::VALUE_W-1:0] level;
    logic [sadt_pkg::VALUE_W-1:0] values [SCAN_LEN];
    logic [sadt_pkg::VALUE_W-1:0] reported [SCAN_LEN];
    bit                           flags [SCAN_LEN];
    logic [sadt_pkg::CHAN_W-1:0]  scan_pos;
    logic [sadt_pkg::BTN_W-1:0]   held_buttons;
    logic [sadt_pkg::BTN_W-1:0]   press_bits;
    logic [sadt_pkg::BTN_W-1:0]   release_bits;
    tracker_result_t              expected_q [$];
    int unsigned                  errors;

    function new();
        deadband = sadt_pkg::DEADBAND_RESET;
        level    = sadt_pkg::BUTTON_LEVEL_RESET;
        foreach (values[i])
        begin
            values[i]   = '0;
            reported[i] = '0;
            flags[i]    = 1'b0;
        end
        scan_pos     = '0;
        held_buttons = '0;
        press_bits   = '0;
        release_bits = '0;
        errors       = 0;
    endfunction

    function void write_register(logic [sadt_pkg::CFG_IDX_W-1:0] idx,
                                 logic [sadt_pkg::VALUE_W-1:0] data);
        case (idx)
            sadt_pkg::REG_DEADBAND:     deadband = data;
            sadt_pkg::REG_BUTTON_LEVEL: level    = data;
            default: ;
        endcase
    endfunction

    function void note_item(logic [sadt_pkg::OP_W-1:0] op, logic [sadt_pkg::VALUE_W-1:0] smp,
                            logic [sadt_pkg::CHAN_W-1:0] ch);
        tracker_result_t            r;
        int unsigned                gap;
        logic [sadt_pkg::BTN_W-1:0] now_pressed;
        logic [sadt_pkg::BTN_W-1:0] toggled;
        r.sampled_channel = '0;
        r.sample_changed  = 1'b0;
        r.read_value      = '0;
        r.read_changed    = 1'b0;
        if (op == sadt_pkg::OP_SAMPLE)
        begin
            r.sampled_channel = scan_pos;
            values[scan_pos]  = smp;
            if (smp >= reported[scan_pos])
                gap = smp - reported[scan_pos];
            else
                gap = reported[scan_pos] - smp;
            if (gap > deadband)
            begin
                flags[scan_pos]    = 1'b1;
                reported[scan_pos] = smp;
                r.sample_changed   = 1'b1;
            end
            scan_pos = (scan_pos == SCAN_LEN - 1) ? '0 : scan_pos + 1'b1;
            now_pressed  = {values[BUTTON_BASE + 1] < level, values[BUTTON_BASE] < level};
            toggled      = now_pressed ^ held_buttons;
            press_bits   = toggled & now_pressed;
            release_bits = toggled & ~now_pressed;
            held_buttons = now_pressed;
        end
        else if (ch < SCAN_LEN)
        begin
            r.read_value   = values[ch];
            r.read_changed = flags[ch];
            if (op == sadt_pkg::OP_READ_CLEAR)
                flags[ch] = 1'b0;
        end
        r.next_channel     = scan_pos;
        r.buttons_state    = held_buttons;
        r.buttons_pressed  = press_bits;
        r.buttons_released = release_bits;
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [sadt_pkg::VALUE_W-1:0] want,
                                logic [sadt_pkg::VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(tracker_result_t got);
        tracker_result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t result with nothing expected: expected none actual next_channel %0d",
                     $time, got.next_channel);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("sampled_channel", want.sampled_channel, got.sampled_channel);
        compare_field("sample_changed", want.sample_changed, got.sample_changed);
        compare_field("next_channel", want.next_channel, got.next_channel);
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("read_changed", want.read_changed, got.read_changed);
        compare_field("buttons_state", want.buttons_state, got.buttons_state);
        compare_field("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
        compare_field("buttons_released", want.buttons_released, got.buttons_released);
    endfunction
endclass

module testbench;

    localparam logic [sadt_pkg::OP_W-1:0] OP_SPARE    = 2'd3;
    localparam int                        QUIET_LIMIT = 4000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [sadt_pkg::OP_W-1:0]      operation = '0;
    logic [sadt_pkg::VALUE_W-1:0]   sample    = '0;
    logic [sadt_pkg::CHAN_W-1:0]    channel   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [sadt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sadt_pkg::VALUE_W-1:0]   cfg_data  = '0;

    logic                           in_stall;
    logic                           out_valid;
    logic [sadt_pkg::CHAN_W-1:0]    sampled_channel;
    logic                           sample_changed;
    logic [sadt_pkg::CHAN_W-1:0]    next_channel;
    logic [sadt_pkg::VALUE_W-1:0]   read_value;
    logic                           read_changed;
    logic [sadt_pkg::BTN_W-1:0]     buttons_state;
    logic [sadt_pkg::BTN_W-1:0]     buttons_pressed;
    logic [sadt_pkg::BTN_W-1:0]     buttons_released;
    logic                           cfg_ready;

    logic [sadt_pkg::VALUE_W-1:0] sweep [18] = '{12'd4095, 12'd0, 12'd10, 12'd11, 12'd2048,
                                                 12'd1, 12'd4094, 12'd100, 12'd99, 12'd3000,
                                                 12'd512, 12'd1023, 12'd1024, 12'd2047,
                                                 12'd7, 12'd4000, 12'd4095, 12'd99};

    bit                   steady       = 1'b0;
    int unsigned          quiet_cycles = 0;
    tracker_scoreboard    sb;

    scanned_adc_deadband_tracker u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .sample           (sample),
        .channel          (channel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sampled_channel  (sampled_channel),
        .sample_changed   (sample_changed),
        .next_channel     (next_channel),
        .read_value       (read_value),
        .read_changed     (read_changed),
        .buttons_state    (buttons_state),
        .buttons_pressed  (buttons_pressed),
        .buttons_released (buttons_released),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 18);

    always @(posedge clk)
    begin : result_monitor
        tracker_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.sampled_channel  = sampled_channel;
            got.sample_changed   = sample_changed;
            got.next_channel     = next_channel;
            got.read_value       = read_value;
            got.read_changed     = read_changed;
            got.buttons_state    = buttons_state;
            got.buttons_pressed  = buttons_pressed;
            got.buttons_released = buttons_released;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(input logic [sadt_pkg::OP_W-1:0] op,
                             input logic [sadt_pkg::VALUE_W-1:0] smp,
                             input logic [sadt_pkg::CHAN_W-1:0] ch);
        bit taken;
        in_valid  <= 1'b1;
        operation <= op;
        sample    <= smp;
        channel   <= ch;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        sb.note_item(op, smp, ch);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid  <= 1'b0;
            operation <= $urandom;
            sample    <= $urandom;
            channel   <= $urandom;
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [sadt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sadt_pkg::VALUE_W-1:0] data);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [sadt_pkg::OP_W-1:0]    op;
        logic [sadt_pkg::VALUE_W-1:0] smp;
        logic [sadt_pkg::CHAN_W-1:0]  ch;
        int                           base;
        int                           val;
        int                           pick;
        int                           p;
        int                           n;
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_item(sadt_pkg::OP_READ, 12'd0, 5'd0);
        push_item(OP_SPARE, 12'd4095, 5'd31);
        push_item(sadt_pkg::OP_READ_CLEAR, 12'd0, 5'd18);
        for (n = 0; n < 18; n++)
            push_item(sadt_pkg::OP_SAMPLE, sweep[n], 5'(n));
        push_item(sadt_pkg::OP_SAMPLE, 12'd4085, 5'd0);
        push_item(sadt_pkg::OP_READ_CLEAR, 12'd0, 5'd0);
        push_item(sadt_pkg::OP_READ, 12'd0, 5'd0);
        push_item(sadt_pkg::OP_READ, 12'd0, 5'd16);

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_register(sadt_pkg::REG_DEADBAND, 12'd0);
                    write_register(sadt_pkg::REG_BUTTON_LEVEL, 12'd4095);
                end
                1:
                begin
                    write_register(sadt_pkg::REG_DEADBAND, 12'd4095);
                    write_register(sadt_pkg::REG_BUTTON_LEVEL, 12'd0);
                end
                3:
                begin
                    write_register(sadt_pkg::REG_DEADBAND, 12'd1);
                    write_register(sadt_pkg::REG_BUTTON_LEVEL, 12'd2048);
                end
                5:
                begin
                    write_register(sadt_pkg::REG_DEADBAND, sadt_pkg::DEADBAND_RESET);
                    write_register(sadt_pkg::REG_BUTTON_LEVEL, sadt_pkg::BUTTON_LEVEL_RESET);
                end
                default:
                begin
                    write_register(sadt_pkg::REG_DEADBAND, 12'($urandom_range(40)));
                    write_register(sadt_pkg::REG_BUTTON_LEVEL, 12'($urandom_range(4095)));
                end
            endcase
            write_register((p == 0) ? 4'd15 : 4'($urandom_range(15, 2)), 12'($urandom));
            steady = (p == 2);

            for (n = 0; n < 215; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    op = sadt_pkg::OP_SAMPLE;
                else if (pick < 75)
                    op = sadt_pkg::OP_READ_CLEAR;
                else if (pick < 90)
                    op = sadt_pkg::OP_READ;
                else
                    op = OP_SPARE;
                base = sb.reported[sb.scan_pos];
                case ($urandom_range(3))
                    0: val = $urandom_range(4095);
                    1:
                    begin
                        val = int'(sb.deadband) + $urandom_range(2) - 1;
                        val = $urandom_range(1) ? base + val : base - val;
                    end
                    2: val = $urandom_range(1) ? 4095 : 0;
                    default:
                    begin
                        if (sb.scan_pos >= 16)
                            val = int'(sb.level) + $urandom_range(8) - 4;
                        else
                            val = base + $urandom_range(8) - 4;
                    end
                endcase
                if (val < 0)
                    val = 0;
                if (val > 4095)
                    val = 4095;
                smp = 12'(val);
                ch = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 18))
                                             : 5'($urandom_range(17));
                push_item(op, smp, ch);
            end
            steady = 1'b0;
        end

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/sadt_pkg.sv
design/sadt_store.sv
design/sadt_buttons.sv
design/scanned_adc_deadband_tracker.sv
bench/testbench.sv
